@@ hw/rtl/spq_pkg.sv @@
// Shared types and codes for the stable priority queue.
package spq_pkg;

	// Item operation codes
	typedef enum logic {
		OP_ENQ = 1'b0,
		OP_DEQ = 1'b1
	} op_t;

	// One stored record, 57 bits
	typedef struct packed {
		logic [3:0]  prio;
		logic [15:0] arrival;
		logic [15:0] service;
		logic [3:0]  server;
		logic        ins;
		logic [15:0] start;
	} rec_t;

	// Command broadcast to every cell in the chain
	typedef struct packed {
		logic enq;
		logic deq;
		rec_t rec;
	} cmd_t;

	localparam int unsigned OCC_W = 7;

endpackage

@@ hw/rtl/spq_cell.sv @@
// One cell of the sorted shift-register queue: holds a record, shifts with its neighbors.
module spq_cell (
	input  logic          clk,
	input  spq_pkg::cmd_t cmd,
	input  logic          occupied,
	input  logic          prev_go,
	input  spq_pkg::rec_t prev_rec,
	input  spq_pkg::rec_t next_rec,
	output logic          go,
	output spq_pkg::rec_t rec
);

	spq_pkg::rec_t rec_q;

	// New record belongs at or before this cell: free slot or lower stored priority
	assign go  = !occupied || (rec_q.prio < cmd.rec.prio);
	assign rec = rec_q;

	// Insert: left neighbor moves in, or the new record lands here; remove: shift toward head
	always_ff @(posedge clk) begin
		if (cmd.enq && go) begin
			rec_q <= prev_go ? prev_rec : cmd.rec;
		end else if (cmd.deq) begin
			rec_q <= next_rec;
		end
	end

endmodule

@@ hw/rtl/stable_priority_queue.sv @@
// Top level of the stable priority queue: cell chain, occupancy count and result register.
//
//  Channel | Handshake          | Payload
//  --------+--------------------+------------------------------------------------------
//  input   | in_valid/in_ready  | opcode priority_req arrival_time service_time
//          |                    | server_id insured start_time
//  output  | out_valid/out_ready| data_valid out_priority out_arrival_time
//          |                    | out_service_time out_server_id out_insured
//          |                    | out_start_time empty_error full_error occupancy
//
// One item per cycle while in_ready is high: every cell compares its priority with the new
// record in parallel and shifts one place, so an insert or a removal completes in the cycle
// the item is accepted. The result is in the output register in the cycle after acceptance.
// in_ready is high while the output register is empty or being drained in the same cycle.
// Reset clears the occupancy count and the output valid; record contents are left as is.
module stable_priority_queue #(
	parameter int unsigned QUEUE_DEPTH = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        opcode,
	input  logic [3:0]  priority_req,
	input  logic [15:0] arrival_time,
	input  logic [15:0] service_time,
	input  logic [3:0]  server_id,
	input  logic        insured,
	input  logic [15:0] start_time,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        data_valid,
	output logic [3:0]  out_priority,
	output logic [15:0] out_arrival_time,
	output logic [15:0] out_service_time,
	output logic [3:0]  out_server_id,
	output logic        out_insured,
	output logic [15:0] out_start_time,
	output logic        empty_error,
	output logic        full_error,
	output logic [6:0]  occupancy
);

	localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
	localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);

	logic                          in_acc;
	logic                          is_deq;
	logic                          is_full;
	logic                          is_empty;
	logic [CW-1:0]                 count_q;
	logic [CW-1:0]                 count_d;
	logic [spq_pkg::OCC_W-1:0]     occ_d;
	spq_pkg::cmd_t                 cmd;
	spq_pkg::rec_t                 new_rec;
	spq_pkg::rec_t                 cell_rec [QUEUE_DEPTH];
	logic [QUEUE_DEPTH-1:0]        cell_go;

	logic                          out_valid_q;
	logic                          data_valid_q;
	spq_pkg::rec_t                 out_rec_q;
	logic                          empty_error_q;
	logic                          full_error_q;
	logic [spq_pkg::OCC_W-1:0]     occupancy_q;

	// Handshake: output register frees up when empty or drained this cycle
	assign in_ready = !out_valid_q || out_ready;
	assign in_acc   = in_valid && in_ready;
	assign is_deq   = (opcode == spq_pkg::OP_DEQ);
	assign is_full  = (count_q >= DEPTH_C);
	assign is_empty = (count_q == '0);

	assign new_rec.prio    = priority_req;
	assign new_rec.arrival = arrival_time;
	assign new_rec.service = service_time;
	assign new_rec.server  = server_id;
	assign new_rec.ins     = insured;
	assign new_rec.start   = start_time;

	// Command to the cells; refused items leave the chain untouched
	always_comb begin
		cmd.enq = in_acc && !is_deq && !is_full;
		cmd.deq = in_acc && is_deq && !is_empty;
		cmd.rec = new_rec;
	end

	// Occupancy after this item
	always_comb begin
		count_d = count_q;
		if (cmd.enq) begin
			count_d = count_q + CW'(1);
		end else if (cmd.deq) begin
			count_d = count_q - CW'(1);
		end
	end

	generate
		if (CW >= spq_pkg::OCC_W) begin : g_occ_trunc
			assign occ_d = count_d[spq_pkg::OCC_W-1:0];
		end else begin : g_occ_ext
			assign occ_d = {{(spq_pkg::OCC_W - CW){1'b0}}, count_d};
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= count_d;
		end
	end

	// Chain of cells, head at index 0
	generate
		for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
			logic          prev_go;
			spq_pkg::rec_t prev_rec;
			spq_pkg::rec_t next_rec;
			logic          occ;

			assign occ = (CW'(i) < count_q);

			if (i == 0) begin : g_head
				assign prev_go  = 1'b0;
				assign prev_rec = new_rec;
			end else begin : g_mid
				assign prev_go  = cell_go[i-1];
				assign prev_rec = cell_rec[i-1];
			end

			if (i == QUEUE_DEPTH - 1) begin : g_tail
				assign next_rec = cell_rec[i];
			end else begin : g_body
				assign next_rec = cell_rec[i+1];
			end

			spq_cell u_cell (
				.clk      (clk),
				.cmd      (cmd),
				.occupied (occ),
				.prev_go  (prev_go),
				.prev_rec (prev_rec),
				.next_rec (next_rec),
				.go       (cell_go[i]),
				.rec      (cell_rec[i])
			);
		end
	endgenerate

	// Result register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_acc) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (in_acc) begin
			data_valid_q  <= cmd.deq;
			out_rec_q     <= cmd.deq ? cell_rec[0] : '0;
			empty_error_q <= is_deq && is_empty;
			full_error_q  <= !is_deq && is_full;
			occupancy_q   <= occ_d;
		end
	end

	assign out_valid        = out_valid_q;
	assign data_valid       = data_valid_q;
	assign out_priority     = out_rec_q.prio;
	assign out_arrival_time = out_rec_q.arrival;
	assign out_service_time = out_rec_q.service;
	assign out_server_id    = out_rec_q.server;
	assign out_insured      = out_rec_q.ins;
	assign out_start_time   = out_rec_q.start;
	assign empty_error      = empty_error_q;
	assign full_error       = full_error_q;
	assign occupancy        = occupancy_q;

	// Count never runs past the store depth
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= DEPTH_C)
		else $error("occupancy count exceeds depth");

	// Dequeue on an empty queue reports the error and no record
	a_empty_deq: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && is_deq && is_empty) |=>
		(out_valid_q && empty_error_q && !data_valid_q && count_q == '0))
		else $error("empty dequeue not flagged");

	// A refused enqueue leaves the count at full
	a_full_enq: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && !is_deq && is_full) |=> (full_error_q && count_q == DEPTH_C))
		else $error("full enqueue not refused");

	// An accepted enqueue grows the count by one
	a_enq_count: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && !is_deq && !is_full) |=> (count_q == $past(count_q) + CW'(1)))
		else $error("enqueue count mismatch");

	// Returned record and error flags are exclusive
	a_flags_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(data_valid_q && (empty_error_q || full_error_q)))
		else $error("record returned together with an error");

endmodule
